// ----- design/cwdc_pkg.sv -----
package cwdc_pkg;

    // List geometry
    localparam int LIST_DEPTH = 16;
    localparam int UID_W      = 32;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int ENTRY_W    = 5;

    // Operation field
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_CARD_SEEN = 3'd0;
    localparam logic [OP_W-1:0] OP_NO_CARD   = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD       = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE    = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;
    localparam logic [OP_W-1:0] OP_DOOR      = 3'd5;

    localparam int DOOR_W = 8;
    localparam logic [DOOR_W-1:0] DOOR_OPEN_CMD = 8'd1;

    // Card event codes
    localparam int EV_W = 2;
    localparam logic [EV_W-1:0] EV_NONE   = 2'd0;
    localparam logic [EV_W-1:0] EV_TOGGLE = 2'd1;
    localparam logic [EV_W-1:0] EV_ALERT  = 2'd2;

    // Configuration space
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_MASTER_UID = 1'b0;
    localparam logic [UID_W-1:0] MASTER_RESET = 32'h81F4_2C07;

    // Search word walking down the cell row
    typedef struct packed {
        logic             vld;
        logic             del;
        logic             found;
        logic [UID_W-1:0] uid;
    } t_tok;

    // Entry handed back to the left neighbor while a delete closes the gap
    typedef struct packed {
        logic             we;
        logic [UID_W-1:0] data;
    } t_back;

endpackage

// ----- design/cwdc_cell.sv -----
module cwdc_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [cwdc_pkg::CNT_W-1:0] i_idx,
    input  logic [cwdc_pkg::CNT_W-1:0] i_count,
    input  logic                       i_add_we,
    input  logic [cwdc_pkg::UID_W-1:0] i_add_uid,
    input  cwdc_pkg::t_tok             i_tok,
    output cwdc_pkg::t_tok             o_tok,
    input  cwdc_pkg::t_back            i_back,
    output cwdc_pkg::t_back            o_back
);
    import cwdc_pkg::*;

    logic [UID_W-1:0] r_entry;
    t_tok             r_tok;
    t_tok             n_tok;
    logic             match;

    // Only entries below the fill count take part in a search
    assign match = i_tok.vld && (i_idx < i_count) && (r_entry == i_tok.uid);

    always_comb begin
        n_tok       = i_tok;
        n_tok.found = i_tok.found | match;
    end

    // Past the deleted entry, hand this entry one place to the left
    assign o_back.we   = i_tok.vld & i_tok.del & i_tok.found;
    assign o_back.data = r_entry;
    assign o_tok       = r_tok;

    always_ff @(posedge i_clk) begin
        if (i_add_we && (i_idx == i_count)) begin
            r_entry <= i_add_uid;
        end else if (i_back.we) begin
            r_entry <= i_back.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

endmodule

// ----- design/card_whitelist_door_controller_top.sv -----
// Channel   | Handshake                      | Payload
// ----------+--------------------------------+---------------------------------------------
// command   | start, busy (word taken when   | i_operation, i_card_uid, i_door_value
//           | start high and busy low)       |
// result    | o_done (one-cycle strobe)      | o_is_authorized, o_door_open, o_card_event,
//           |                                | o_op_status, o_entry_count
// config    | psel, penable, pwrite, pready  | paddr, pwdata, prdata (master_uid at 0x0)
//
// Card seen and delete send a search word down the row of LIST_DEPTH cells, one cell
// per cycle: o_done rises as busy drops, once the word has left the last cell and the
// result is registered. Later entries shift left as a delete passes.
// For all other operations o_done is high right after the taking edge.
// Reset is synchronous: empty list, door locked, no card present, master ID restored.
// The receiver cannot stall; each result is shown for exactly one cycle.
module card_whitelist_door_controller_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cwdc_pkg::OP_W-1:0]     i_operation,
    input  logic [cwdc_pkg::UID_W-1:0]    i_card_uid,
    input  logic [cwdc_pkg::DOOR_W-1:0]   i_door_value,
    output logic                          o_done,
    output logic                          o_is_authorized,
    output logic                          o_door_open,
    output logic [cwdc_pkg::EV_W-1:0]     o_card_event,
    output logic                          o_op_status,
    output logic [cwdc_pkg::ENTRY_W-1:0]  o_entry_count,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cwdc_pkg::PADDR_W-1:0]  paddr,
    input  logic [cwdc_pkg::PDATA_W-1:0]  pwdata,
    output logic [cwdc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import cwdc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } t_state;

    t_state           r_state, n_state;
    t_tok             r_tok, n_tok;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_door, n_door;
    logic             r_card_present, n_card_present;
    logic             r_done, n_done;
    logic             r_auth, n_auth;
    logic [EV_W-1:0]  r_event, n_event;
    logic             r_status, n_status;
    logic [UID_W-1:0] r_master;

    logic             accept;
    logic             add_we;
    logic             auth;
    logic             cfg_we;
    t_tok             tok  [0:LIST_DEPTH];
    t_back            back [0:LIST_DEPTH];

    assign busy   = (r_state == ST_WALK);
    assign accept = start & ~busy;

    // ---------------------------------------------------------------------
    // Configuration port: master ID at word 0, everything else reads zero
    // ---------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready & (paddr[2] == REG_MASTER_UID);
    assign prdata = (paddr[2] == REG_MASTER_UID) ? r_master : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master <= MASTER_RESET;
        end else if (cfg_we) begin
            r_master <= pwdata;
        end
    end

    // ---------------------------------------------------------------------
    // Cell row: tok[0] enters cell 0, tok[LIST_DEPTH] leaves the last cell
    // ---------------------------------------------------------------------
    assign tok[0]           = r_tok;
    assign back[LIST_DEPTH] = '0;

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        cwdc_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_idx     (CNT_W'(g)),
            .i_count   (r_count),
            .i_add_we  (add_we),
            .i_add_uid (i_card_uid),
            .i_tok     (tok[g]),
            .o_tok     (tok[g+1]),
            .i_back    (back[g+1]),
            .o_back    (back[g])
        );
    end

    // Card is authorized by the master ID or by any live list entry
    assign auth = tok[LIST_DEPTH].found | (tok[LIST_DEPTH].uid == r_master);

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        n_state        = r_state;
        n_tok          = r_tok;
        n_tok.vld      = 1'b0;
        n_count        = r_count;
        n_door         = r_door;
        n_card_present = r_card_present;
        n_done         = 1'b0;
        n_auth         = 1'b0;
        n_event        = EV_NONE;
        n_status       = 1'b0;
        add_we         = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_operation)
                        OP_CARD_SEEN, OP_DELETE: begin
                            // Launch the search word down the row
                            n_tok.vld   = 1'b1;
                            n_tok.del   = (i_operation == OP_DELETE);
                            n_tok.found = 1'b0;
                            n_tok.uid   = i_card_uid;
                            n_state     = ST_WALK;
                        end
                        OP_NO_CARD: begin
                            n_card_present = 1'b0;
                            n_done         = 1'b1;
                        end
                        OP_ADD: begin
                            // Append at the fill count, or flag a full list
                            if (r_count < CNT_W'(LIST_DEPTH)) begin
                                add_we  = 1'b1;
                                n_count = r_count + 1'b1;
                            end else begin
                                n_status = 1'b1;
                            end
                            n_done = 1'b1;
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                            n_done  = 1'b1;
                        end
                        OP_DOOR: begin
                            n_door = (i_door_value == DOOR_OPEN_CMD);
                            n_done = 1'b1;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                // Finish when the search word drops off the last cell
                if (tok[LIST_DEPTH].vld) begin
                    n_state = ST_IDLE;
                    n_done  = 1'b1;
                    if (tok[LIST_DEPTH].del) begin
                        if (tok[LIST_DEPTH].found) begin
                            n_count = r_count - 1'b1;
                        end else begin
                            n_status = 1'b1;
                        end
                    end else begin
                        n_auth = auth;
                        // Act only on a fresh card, not one that is held
                        if (!r_card_present) begin
                            if (auth) begin
                                n_door  = ~r_door;
                                n_event = EV_TOGGLE;
                            end else begin
                                n_event = EV_ALERT;
                            end
                        end
                        n_card_present = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_tok          <= '0;
            r_count        <= '0;
            r_door         <= 1'b0;
            r_card_present <= 1'b0;
            r_done         <= 1'b0;
            r_auth         <= 1'b0;
            r_event        <= EV_NONE;
            r_status       <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_tok          <= n_tok;
            r_count        <= n_count;
            r_door         <= n_door;
            r_card_present <= n_card_present;
            r_done         <= n_done;
            r_auth         <= n_auth;
            r_event        <= n_event;
            r_status       <= n_status;
        end
    end

    // Door state and count registers already hold the post-item values
    assign o_done          = r_done;
    assign o_is_authorized = r_auth;
    assign o_door_open     = r_door;
    assign o_card_event    = r_event;
    assign o_op_status     = r_status;
    assign o_entry_count   = ENTRY_W'(r_count);

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_no_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_done && busy))
        else $error("result strobe while a search is in flight");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(LIST_DEPTH))
        else $error("fill count beyond list depth");

    a_short_op_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_operation != OP_CARD_SEEN) && (i_operation != OP_DELETE))
        |=> o_done)
        else $error("one-cycle operation gave no result");

    a_walk_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && tok[LIST_DEPTH].vld) |=> (o_done && !busy))
        else $error("search finished without a result");

endmodule
